### hw/rtl/lpn_pkg.sv
// shared types and constants of the led pixel node controller
`timescale 1ns / 1ps
`default_nettype none

package lpn_pkg;

  // event kinds
  localparam logic [1:0] MODE_CMD    = 2'd0;
  localparam logic [1:0] MODE_BUTTON = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  // command byte fields
  localparam logic [7:0] CMD_MASK    = 8'hE0;
  localparam logic [7:0] CMD_STORE   = 8'h80;
  localparam logic [7:0] CMD_RECALL  = 8'h40;
  localparam logic [7:0] CMD_PALETTE = 8'h20;
  localparam int         SLOT_BITS   = 5;

  // configuration register indexes
  localparam logic CFG_COLOR_COUNT  = 1'b0;
  localparam logic CFG_IDLE_SECONDS = 1'b1;

  // configuration reset values and the upper bound of the colour count
  localparam logic [6:0]  COUNT_RESET = 7'd7;
  localparam logic [15:0] IDLE_RESET  = 16'd900;
  localparam logic [6:0]  COUNT_MAX   = 7'd64;

  // remainder unit: one quotient bit per cycle over a 6-bit dividend
  localparam int         DIV_STEPS = 6;
  localparam logic [2:0] DIV_LAST  = 3'(DIV_STEPS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ACCESS,
    S_LOAD_RD,
    S_LOAD_DIV,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/led_pixel_node_controller.sv
// led pixel node controller: command, button and tick event handling over a slot memory
// button, tick, palette and error events pass exec and done; a save adds access, a load
// adds access and read, and a load of a written slot adds the remainder steps as well
// one event at a time: the next transaction is taken the cycle after the result is
// registered; the load remainder takes 6 steps
// synchronous reset clears the index, timer, press flag and per-slot valid bits at once;
// a slot not written since reset reads as erased, so no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module led_pixel_node_controller #(
  parameter int SLOT_COUNT = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        button_down,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       color_index,
  output logic             relay_valid,
  output logic [7:0]       relay_byte,
  output logic             command_error,
  output logic             boot_slot_written
);

  import lpn_pkg::*;

  // save slots plus the power-on slot at the top address
  localparam int SLOT_DEPTH = SLOT_COUNT + 1;
  localparam int ADDR_W     = $clog2(SLOT_DEPTH);
  localparam logic [ADDR_W-1:0] BOOT_ADDR = ADDR_W'(SLOT_COUNT);

  state_t state, state_next;

  // configuration
  logic [6:0]  color_count;
  logic [15:0] idle_seconds;
  logic [6:0]  eff_count;

  // node state
  logic [5:0]  current_index;
  logic        press_latched;
  logic [15:0] idle_count;
  logic        timer_running;

  // captured event
  logic [1:0] cap_mode;
  logic [7:0] cap_byte;
  logic       cap_down;
  logic [7:0] cmd;

  // pending result
  logic       res_relay_valid;
  logic [7:0] res_relay_byte;
  logic       res_err;
  logic       res_written;

  // slot memory
  logic [5:0]            mem [SLOT_DEPTH];
  logic [SLOT_DEPTH-1:0] slot_valid;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic                  mem_re;
  logic [ADDR_W-1:0]     slot_addr;
  logic [5:0]            rd_data;
  logic                  rd_valid;

  // remainder unit
  logic [6:0] div_rem;
  logic [5:0] div_dvd;
  logic [6:0] div_dsr;
  logic [2:0] div_cnt;
  logic [6:0] div_trial;
  logic [6:0] div_rem_step;
  logic       div_last;
  logic       div_load;
  logic [5:0] div_dvd_in;
  logic [6:0] div_dsr_in;

  logic [16:0] tick_count;
  logic        expire;
  logic [6:0]  press_next;
  logic        out_free;

  // slot number folded into the slot range by a constant table
  function automatic logic [SLOT_BITS-1:0] slot_fold(input logic [SLOT_BITS-1:0] s);
    slot_fold = '0;
    for (int i = 0; i < 2**SLOT_BITS; i++) begin
      if (s == SLOT_BITS'(i)) slot_fold = SLOT_BITS'(i % SLOT_COUNT);
    end
  endfunction

  assign cmd        = cap_byte & CMD_MASK;
  assign slot_addr  = ADDR_W'(slot_fold(cap_byte[SLOT_BITS-1:0]));
  assign tick_count = {1'b0, idle_count} + 17'd1;
  assign expire     = tick_count >= {1'b0, idle_seconds};
  assign press_next = {1'b0, current_index} + 7'd1;
  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state != S_IDLE);

  always_comb begin
    if (color_count == 7'd0) begin
      eff_count = 7'd1;
    end else if (color_count > COUNT_MAX) begin
      eff_count = COUNT_MAX;
    end else begin
      eff_count = color_count;
    end
  end

  // restoring remainder step
  assign div_trial    = {div_rem[5:0], div_dvd[5]};
  assign div_rem_step = (div_trial >= div_dsr) ? (div_trial - div_dsr) : div_trial;
  assign div_last     = (div_cnt == DIV_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = slot_addr;
    mem_re     = 1'b0;
    div_load   = 1'b0;
    div_dvd_in = rd_data;
    div_dsr_in = eff_count;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        priority if (cap_mode == MODE_CMD && (cmd == CMD_STORE || cmd == CMD_RECALL)) begin
          state_next = S_ACCESS;
        end else if (cap_mode == MODE_TICK && timer_running && expire) begin
          mem_we     = 1'b1;
          mem_waddr  = BOOT_ADDR;
          state_next = S_DONE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_ACCESS: begin
        if (cmd == CMD_STORE) begin
          mem_we     = 1'b1;
          state_next = S_DONE;
        end else begin
          mem_re     = 1'b1;
          state_next = S_LOAD_RD;
        end
      end
      S_LOAD_RD: begin
        if (rd_valid) begin
          div_load   = 1'b1;
          state_next = S_LOAD_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_LOAD_DIV: begin
        if (div_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // slot memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= current_index;
    if (mem_re) begin
      rd_data  <= mem[slot_addr];
      rd_valid <= slot_valid[slot_addr];
    end
  end

  // remainder unit
  always_ff @(posedge clk) begin
    if (div_load) begin
      div_rem <= 7'd0;
      div_dvd <= div_dvd_in;
      div_dsr <= div_dsr_in;
      div_cnt <= 3'd0;
    end else begin
      div_rem <= div_rem_step;
      div_dvd <= {div_dvd[4:0], 1'b0};
      div_cnt <= div_cnt + 3'd1;
    end
  end

  // event capture
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cap_mode <= mode;
      cap_byte <= rx_byte;
      cap_down <= button_down;
    end
  end

  // configuration and node state
  always_ff @(posedge clk) begin
    if (rst) begin
      color_count   <= COUNT_RESET;
      idle_seconds  <= IDLE_RESET;
      current_index <= 6'd0;
      press_latched <= 1'b0;
      idle_count    <= 16'd0;
      timer_running <= 1'b0;
      slot_valid    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COLOR_COUNT:  color_count  <= cfg_data[6:0];
          CFG_IDLE_SECONDS: idle_seconds <= cfg_data;
          default:          ;
        endcase
      end

      if (state == S_EXEC) begin
        if (cap_mode == MODE_BUTTON) begin
          if (cap_down && !press_latched) begin
            press_latched <= 1'b1;
            current_index <= (press_next >= eff_count) ? 6'd0 : press_next[5:0];
            idle_count    <= 16'd0;
            timer_running <= 1'b1;
          end else if (!cap_down && press_latched) begin
            press_latched <= 1'b0;
          end
        end else if (cap_mode == MODE_TICK && timer_running) begin
          if (expire) begin
            idle_count    <= 16'd0;
            timer_running <= 1'b0;
          end else begin
            idle_count <= tick_count[15:0];
          end
        end
      end

      // erased slot loads as index zero
      if (state == S_LOAD_RD && !rd_valid) current_index <= 6'd0;
      if (state == S_LOAD_DIV && div_last) current_index <= div_rem_step[5:0];

      if (mem_we) slot_valid[mem_waddr] <= 1'b1;

      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pending result fields
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      res_relay_valid <= 1'b0;
      res_relay_byte  <= 8'd0;
      res_err         <= 1'b0;
      res_written     <= 1'b0;
      if (cap_mode == MODE_CMD) begin
        if (cmd == CMD_STORE || cmd == CMD_RECALL || cmd == CMD_PALETTE) begin
          res_relay_valid <= 1'b1;
          res_relay_byte  <= cap_byte;
        end else begin
          res_err <= 1'b1;
        end
      end else if (cap_mode == MODE_TICK && timer_running && expire) begin
        res_written <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      color_index       <= current_index;
      relay_valid       <= res_relay_valid;
      relay_byte        <= res_relay_byte;
      command_error     <= res_err;
      boot_slot_written <= res_written;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lpn_checker.sv
// port-level checks of the led pixel node controller and their bind
`timescale 1ns / 1ps
`default_nettype none

module lpn_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [5:0] color_index,
  input wire logic       relay_valid,
  input wire logic [7:0] relay_byte,
  input wire logic       command_error,
  input wire logic       boot_slot_written
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(color_index) && $stable(relay_byte)
      && $stable(relay_valid) && $stable(command_error) && $stable(boot_slot_written))
    else $error("stalled result changed");

  // one event in flight: an accepted transaction closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an event is in flight");

  a_relay_or_error: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(relay_valid && command_error))
    else $error("relay and error flagged together");

  a_relay_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !relay_valid |-> relay_byte == 8'd0)
    else $error("relay byte set without relay");

  a_boot_write_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && boot_slot_written |-> !relay_valid && !command_error)
    else $error("power-on slot write on a command event");

endmodule

bind led_pixel_node_controller lpn_checker u_lpn_checker (.*);

`default_nettype wire
